// ----- sv/bnms_pkg.sv -----
package bnms_pkg;

   localparam int MaxBoxes = 64;
   localparam int IdxW = $clog2(MaxBoxes);
   localparam int CntW = $clog2(MaxBoxes + 1);

   localparam logic [7:0] ThresholdReset = 8'd128;

   typedef enum logic [0:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_UNION = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic scan_clear;
      logic scan_step;
      logic sup_start;
      logic sup_step;
      logic emit;
      logic finish;
   } bnms_cmd_type;

   typedef struct packed {
      logic any_live;
      logic scan_last;
      logic sup_last;
   } bnms_status_type;

endpackage

// ----- sv/bnms_ctrl.sv -----
module bnms_ctrl
   import bnms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  bnms_status_type status,
   output bnms_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_START, S_SCAN, S_SUP_START, S_SUP, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (go) state_in = S_SCAN_START;
         end
         S_SCAN_START: begin
            if (!status.any_live) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = S_SUP_START;
         end
         S_SUP_START: begin
            cmd.sup_start = 1'b1;
            state_in = S_SUP;
         end
         S_SUP: begin
            cmd.sup_step = 1'b1;
            if (status.sup_last) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_SCAN_START;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_emit_after_sup: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $past(state_ff) == S_SUP)
      else $error("emit without suppression pass");
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && go) |=> state_ff == S_SCAN_START)
      else $error("go not taken");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("finish did not return idle");

endmodule

// ----- sv/bnms_datapath.sv -----
module bnms_datapath
   import bnms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic signed [15:0]    in_left,
   input  logic signed [15:0]    in_top,
   input  logic signed [15:0]    in_right,
   input  logic signed [15:0]    in_bottom,
   input  logic [15:0]           in_score,
   input  logic [7:0]            threshold,
   input  logic                  union_mode,
   input  bnms_cmd_type          cmd,
   output bnms_status_type       status,
   output logic                  out_valid,
   output logic [5:0]            out_index,
   output logic signed [15:0]    out_left,
   output logic signed [15:0]    out_top,
   output logic signed [15:0]    out_right,
   output logic signed [15:0]    out_bottom,
   output logic [15:0]           out_score,
   output logic                  out_overflow,
   output logic                  out_last
);

   logic [63:0]          corner_mem [MaxBoxes];
   logic [15:0]          score_mem [MaxBoxes];
   logic [MaxBoxes-1:0]  live_ff;
   logic [CntW-1:0]      count_ff;
   logic                 dropped_ff;

   // scan: read address rd_ff, data registered the cycle after
   logic [CntW-1:0]      rd_ff;
   logic [IdxW-1:0]      rd_idx_q_ff;
   logic                 rd_vld_ff;
   logic [63:0]          rd_corner_ff;
   logic [15:0]          rd_score_ff;

   logic                 found_ff;
   logic [IdxW-1:0]      pick_ff;
   logic [15:0]          best_ff;
   logic [63:0]          pick_corner_ff;

   logic                 full;
   assign full = (count_ff == CntW'(MaxBoxes));

   always_ff @(posedge clock) begin
      if (load && !full) begin
         corner_mem[count_ff[IdxW-1:0]] <= {in_bottom, in_right, in_top, in_left};
         score_mem[count_ff[IdxW-1:0]] <= in_score;
      end
      rd_corner_ff <= corner_mem[rd_ff[IdxW-1:0]];
      rd_score_ff <= score_mem[rd_ff[IdxW-1:0]];
   end

   logic rd_end;
   assign rd_end = (rd_ff >= count_ff);
   logic active;
   assign active = cmd.scan_step || cmd.sup_step;

   // stage A: overlap terms (registered), stage B: products, stage C: compare
   logic signed [15:0] pl, pt, pr, pb, jl, jt, jr, jb;
   assign {pb, pr, pt, pl} = pick_corner_ff;
   assign {jb, jr, jt, jl} = rd_corner_ff;

   function automatic logic [16:0] span(input logic signed [15:0] lo,
                                        input logic signed [15:0] hi);
      logic signed [16:0] d;
      d = 17'(hi) - 17'(lo);
      span = (hi > lo) ? 17'(d) : 17'd0;
   endfunction

   logic [16:0] iw_ff, ih_ff, pw_ff, ph_ff, jw_ff, jh_ff;
   logic        a_vld_ff, b_vld_ff;
   logic [IdxW-1:0] a_idx_ff, b_idx_ff;
   logic [33:0] inter_ff, ap_ff, aj_ff;

   logic [34:0] den;
   always_comb begin
      if (union_mode) den = 35'(ap_ff) + 35'(aj_ff) - 35'(inter_ff);
      else den = (ap_ff < aj_ff) ? 35'(ap_ff) : 35'(aj_ff);
   end
   logic suppress;
   assign suppress = ({inter_ff, 8'd0} > 42'(42'(threshold) * 42'(den)));

   logic pipe_busy;
   assign pipe_busy = rd_vld_ff || a_vld_ff || b_vld_ff;

   always_ff @(posedge clock) begin
      iw_ff <= span((pl > jl) ? pl : jl, (pr < jr) ? pr : jr);
      ih_ff <= span((pt > jt) ? pt : jt, (pb < jb) ? pb : jb);
      pw_ff <= span(pl, pr);
      ph_ff <= span(pt, pb);
      jw_ff <= span(jl, jr);
      jh_ff <= span(jt, jb);
      a_idx_ff <= rd_idx_q_ff;
      b_idx_ff <= a_idx_ff;
      inter_ff <= 34'(iw_ff * ih_ff);
      ap_ff <= 34'(pw_ff * ph_ff);
      aj_ff <= 34'(jw_ff * jh_ff);
      rd_idx_q_ff <= rd_ff[IdxW-1:0];
      if (cmd.emit) begin
         out_index <= 6'(pick_ff);
         {out_bottom, out_right, out_top, out_left} <= pick_corner_ff;
         out_score <= best_ff;
         out_overflow <= dropped_ff;
         out_last <= (live_ff == '0);
      end
      if (cmd.scan_step && rd_vld_ff && live_ff[rd_idx_q_ff] &&
          (!found_ff || rd_score_ff >= best_ff)) begin
         pick_ff <= rd_idx_q_ff;
         best_ff <= rd_score_ff;
         pick_corner_ff <= rd_corner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         rd_ff <= '0;
         rd_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         out_valid <= cmd.emit;
         a_vld_ff <= rd_vld_ff && cmd.sup_step;
         b_vld_ff <= a_vld_ff;
         if (load) begin
            if (full) dropped_ff <= 1'b1;
            else begin
               live_ff[count_ff[IdxW-1:0]] <= 1'b1;
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.scan_clear || cmd.sup_start) begin
            rd_ff <= '0;
            rd_vld_ff <= 1'b0;
         end else if (active) begin
            rd_vld_ff <= !rd_end;
            if (!rd_end) rd_ff <= rd_ff + 1'b1;
         end else begin
            rd_vld_ff <= 1'b0;
         end
         if (cmd.scan_clear) found_ff <= 1'b0;
         else if (cmd.scan_step && rd_vld_ff && live_ff[rd_idx_q_ff]) found_ff <= 1'b1;
         if (cmd.sup_start) live_ff[pick_ff] <= 1'b0;
         if (b_vld_ff && live_ff[b_idx_ff] && suppress) live_ff[b_idx_ff] <= 1'b0;
         if (cmd.finish) begin
            live_ff <= '0;
            count_ff <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   // Scan end: address past count and nothing left in flight
   logic scan_done;
   assign scan_done = rd_end && !rd_vld_ff;

   assign status.any_live = (live_ff != '0);
   assign status.scan_last = scan_done;
   assign status.sup_last = rd_end && !pipe_busy && !cmd.sup_start;

   a_pick_live: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !live_ff[pick_ff])
      else $error("pick still live at emit");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxBoxes))
      else $error("box count overflow");
   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      cmd.sup_start |-> found_ff)
      else $error("suppression without a pick");

endmodule

// ----- sv/bbox_non_max_suppression.sv -----
// Greedy NMS. Boxes load one per cycle while busy is low (start high); the
// box with final_box set starts suppression and raises busy. Each pick makes
// one scan over the box memory to find the top score and one pass through
// the 3-stage overlap pipeline, and once no box is live the controller
// closes the set. Each kept box appears on rsp_* for one cycle with
// rsp_valid, registered from the emit state that follows its pick. The
// receiver cannot stall; busy drops the cycle after the last kept box.
module bbox_non_max_suppression
   import bnms_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_left_edge,
   input  logic signed [15:0] req_top_edge,
   input  logic signed [15:0] req_right_edge,
   input  logic signed [15:0] req_bottom_edge,
   input  logic [15:0]        req_confidence,
   input  logic               req_final_box,
   output logic               rsp_valid,
   output logic [5:0]         rsp_kept_index,
   output logic signed [15:0] rsp_kept_left,
   output logic signed [15:0] rsp_kept_top,
   output logic signed [15:0] rsp_kept_right,
   output logic signed [15:0] rsp_kept_bottom,
   output logic [15:0]        rsp_kept_score,
   output logic               rsp_overflow_flag,
   output logic               rsp_end_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_data
);

   logic [7:0]      threshold_ff;
   logic            union_ff;
   bnms_cmd_type    cmd;
   bnms_status_type status;
   logic            load;
   logic            ctrl_busy;

   assign csr_ready = 1'b1;
   assign load = start && !busy;
   assign busy = ctrl_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         union_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_UNION: union_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   bnms_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(load && req_final_box),
      .status(status), .cmd(cmd), .busy(ctrl_busy)
   );

   bnms_datapath u_dp (
      .clock(clock), .reset(reset), .load(load),
      .in_left(req_left_edge), .in_top(req_top_edge),
      .in_right(req_right_edge), .in_bottom(req_bottom_edge),
      .in_score(req_confidence), .threshold(threshold_ff), .union_mode(union_ff),
      .cmd(cmd), .status(status), .out_valid(rsp_valid),
      .out_index(rsp_kept_index), .out_left(rsp_kept_left),
      .out_top(rsp_kept_top), .out_right(rsp_kept_right),
      .out_bottom(rsp_kept_bottom), .out_score(rsp_kept_score),
      .out_overflow(rsp_overflow_flag), .out_last(rsp_end_of_run)
   );

endmodule

// ----- dv/bbox_non_max_suppression_tb.sv -----
`timescale 1ns / 100ps

module bbox_non_max_suppression_tb;
   import bnms_pkg::*;

   typedef struct {
      logic signed [15:0] x1, y1, x2, y2;
      logic [15:0]        score;
   } box_type;

   typedef struct {
      logic [5:0]         index;
      logic signed [15:0] x1, y1, x2, y2;
      logic [15:0]        score;
      logic               overflow, last;
   } kept_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_left_edge = 0, req_top_edge = 0, req_right_edge = 0;
   logic signed [15:0] req_bottom_edge = 0;
   logic [15:0] req_confidence = 0;
   logic req_final_box = 0;
   logic rsp_valid;
   logic [5:0] rsp_kept_index;
   logic signed [15:0] rsp_kept_left, rsp_kept_top, rsp_kept_right, rsp_kept_bottom;
   logic [15:0] rsp_kept_score;
   logic rsp_overflow_flag, rsp_end_of_run;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_THRESHOLD;
   logic [7:0] csr_data = 0;

   bbox_non_max_suppression dut (.*);

   // predictor state
   box_type     boxes[MaxBoxes];
   logic [63:0] live;
   int          loaded;
   logic        dropped;
   logic [7:0]  thresh;
   logic        by_union;
   kept_type    kept_q[$];

   int errors = 0;
   int sets_done = 0;
   int boxes_sent = 0;
   int kept_seen = 0;
   int cycles = 0;
   int burst_left = 0;

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("bbox_non_max_suppression_tb: done, errors");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   function automatic longint span(input int lo, input int hi);
      return hi > lo ? longint'(hi - lo) : 0;
   endfunction

   function automatic longint area(input box_type b);
      return span(b.x1, b.x2) * span(b.y1, b.y2);
   endfunction

   function automatic bit overlaps(input box_type p, input box_type q);
      longint iw, ih, inter, ap, aq, den;
      iw = span(p.x1 > q.x1 ? p.x1 : q.x1, p.x2 < q.x2 ? p.x2 : q.x2);
      ih = span(p.y1 > q.y1 ? p.y1 : q.y1, p.y2 < q.y2 ? p.y2 : q.y2);
      inter = iw * ih;
      ap = area(p);
      aq = area(q);
      den = by_union ? ap + aq - inter : (ap < aq ? ap : aq);
      return inter * 256 > longint'(thresh) * den;
   endfunction

   task automatic predict_nms(input box_type b, input bit fin);
      int pick;
      kept_type k;
      if (loaded < MaxBoxes) begin
         boxes[loaded] = b;
         live[loaded] = 1'b1;
         loaded++;
      end else begin
         dropped = 1'b1;
      end
      if (!fin) return;
      while (live != 0) begin
         pick = -1;
         for (int i = 0; i < loaded; i++)
            if (live[i] && (pick < 0 || boxes[i].score >= boxes[pick].score)) pick = i;
         for (int i = 0; i < loaded; i++)
            if (live[i] && i != pick && overlaps(boxes[pick], boxes[i])) live[i] = 1'b0;
         live[pick] = 1'b0;
         k.index = pick[5:0];
         k.x1 = boxes[pick].x1;
         k.y1 = boxes[pick].y1;
         k.x2 = boxes[pick].x2;
         k.y2 = boxes[pick].y2;
         k.score = boxes[pick].score;
         k.overflow = dropped;
         k.last = (live == 0);
         kept_q = {kept_q, k};
      end
      loaded = 0;
      live = '0;
      dropped = 1'b0;
      sets_done++;
   endtask

   always @(posedge clock) begin
      kept_type e;
      if (!reset && rsp_valid) begin
         kept_seen++;
         if (kept_q.size() == 0) begin
            report("unexpected kept box, index", rsp_kept_index, -1);
         end else begin
            e = kept_q.pop_front();
            if (rsp_kept_index !== e.index) report("kept_index", rsp_kept_index, e.index);
            if (rsp_kept_left !== e.x1) report("kept_left", rsp_kept_left, e.x1);
            if (rsp_kept_top !== e.y1) report("kept_top", rsp_kept_top, e.y1);
            if (rsp_kept_right !== e.x2) report("kept_right", rsp_kept_right, e.x2);
            if (rsp_kept_bottom !== e.y2) report("kept_bottom", rsp_kept_bottom, e.y2);
            if (rsp_kept_score !== e.score) report("kept_score", rsp_kept_score, e.score);
            if (rsp_overflow_flag !== e.overflow)
               report("overflow_flag", rsp_overflow_flag, e.overflow);
            if (rsp_end_of_run !== e.last) report("end_of_run", rsp_end_of_run, e.last);
         end
      end
   end

   // random gaps between bursts when paced
   task automatic send_box(input box_type b, input bit fin, input bit paced = 1);
      int gap;
      gap = 0;
      @(negedge clock);
      if (paced) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_left_edge <= b.x1;
      req_top_edge <= b.y1;
      req_right_edge <= b.x2;
      req_bottom_edge <= b.y2;
      req_confidence <= b.score;
      req_final_box <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_nms(b, fin);
      boxes_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (kept_q.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_THRESHOLD) thresh = val;
      else by_union = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic box_type mk(input int x1, y1, x2, y2, input int s);
      box_type b;
      b.x1 = 16'(x1);
      b.y1 = 16'(y1);
      b.x2 = 16'(x2);
      b.y2 = 16'(y2);
      b.score = 16'(s);
      return b;
   endfunction

   function automatic box_type rand_box(input bit clustered);
      box_type b;
      int cx, cy;
      if (clustered) begin
         cx = int'($urandom_range(0, 2000)) - 1000;
         cy = int'($urandom_range(0, 2000)) - 1000;
         b.x1 = 16'(cx);
         b.y1 = 16'(cy);
         b.x2 = 16'(cx + int'($urandom_range(0, 600)) - 40);
         b.y2 = 16'(cy + int'($urandom_range(0, 600)) - 40);
         b.score = $urandom_range(0, 7) == 0 ? 16'h8000 : 16'($urandom);
      end else begin
         b.x1 = 16'($urandom);
         b.y1 = 16'($urandom);
         b.x2 = 16'($urandom);
         b.y2 = 16'($urandom);
         b.score = 16'($urandom);
      end
      return b;
   endfunction

   task automatic test_directed();
      send_box(mk(-32768, -32768, 32767, 32767, 16'hFFFF), 0);
      send_box(mk(0, 0, 32767, 32767, 16'hFFFF), 0);
      send_box(mk(100, 100, 50, 50, 0), 0);
      send_box(mk(0, 0, 0, 0, 16'h1234), 0);
      send_box(mk(10, 10, 200, 200, 16'h1234), 0);
      send_box(mk(20, 20, 210, 210, 16'h0001), 1);
      drain();
      send_box(mk(5, 5, 6, 6, 16'h7777), 1);
      drain();
      send_box(mk(32767, 32767, -32768, -32768, 0), 0);
      send_box(mk(-16, -16, 16, 16, 16'hAAAA), 0);
      send_box(mk(-16, -16, 16, 16, 16'h5555), 1);
      drain();
   endtask

   task automatic test_overflow();
      for (int i = 0; i <= MaxBoxes + 1; i++)
         send_box(rand_box(1), i == MaxBoxes + 1);
      drain();
      for (int i = 0; i <= MaxBoxes; i++)
         send_box(rand_box(1), i == MaxBoxes);
      drain();
   endtask

   task automatic test_random_sets(input int n_boxes);
      int sent;
      int sz;
      sent = 0;
      while (sent < n_boxes) begin
         sz = $urandom_range(0, 9) == 0 ? $urandom_range(20, MaxBoxes) : $urandom_range(1, 8);
         for (int i = 0; i < sz; i++) send_box(rand_box($urandom_range(0, 4) != 0), i == sz - 1);
         sent += sz;
         if ($urandom_range(0, 3) == 0) drain();
      end
      drain();
   endtask

   task automatic test_back_to_back();
      for (int s = 0; s < 10; s++) begin
         int sz;
         sz = $urandom_range(1, 5);
         for (int i = 0; i < sz; i++) send_box(rand_box(1), i == sz - 1, 0);
      end
      drain();
   endtask

   initial begin
      live = '0;
      loaded = 0;
      dropped = 0;
      thresh = ThresholdReset;
      by_union = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_directed();
      test_overflow();
      test_random_sets(30);
      write_csr(CSR_THRESHOLD, 8'd0);
      write_csr(CSR_UNION, 8'd0);
      test_random_sets(30);
      write_csr(CSR_THRESHOLD, 8'd255);
      test_random_sets(30);
      write_csr(CSR_UNION, 8'd1);
      test_back_to_back();
      write_csr(CSR_THRESHOLD, 8'($urandom_range(40, 200)));
      write_csr(CSR_UNION, 8'd0);
      test_random_sets(30);
      write_csr(CSR_THRESHOLD, 8'd128);
      write_csr(CSR_UNION, 8'd1);
      test_random_sets(20);

      drain();
      $display("covered %0d boxes in %0d sets, %0d kept boxes checked",
               boxes_sent, sets_done, kept_seen);
      $display("thresholds 0, 255, mid and reset in both overlap modes, incl. set overflow");
      if (errors == 0 && kept_q.size() == 0) begin
         $display("bbox_non_max_suppression_tb: done, clean");
      end else begin
         $display("%0d errors, %0d kept boxes missing", errors, kept_q.size());
         $display("bbox_non_max_suppression_tb: done, errors");
      end
      $finish;
   end
endmodule
